// ===== sv/keyframe_joint_interpolator_top_assert.svh =====
// Assertion macros for the keyframe joint interpolator.
// Included by the top module to check its own logic; needs i_clk and i_rst_n in scope.
`ifndef KEYFRAME_JOINT_INTERPOLATOR_TOP_ASSERT_SVH
`define KEYFRAME_JOINT_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define KJI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define KJI_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define KJI_ASSERT(lbl, prop, msg)
`define KJI_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/kji_pkg.sv =====
// Package for the keyframe joint interpolator: beat types, codes and constants.
// No dependencies.
package kji_pkg;

    localparam int JOINT_W = 4;
    localparam int JOINTS  = 16;

    localparam logic [1:0] KIND_FRAME_TIME = 2'd0;
    localparam logic [1:0] KIND_ANGLE      = 2'd1;
    localparam logic [1:0] KIND_SAMPLE     = 2'd2;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_LOADED  = 2'd1;
    localparam logic [1:0] ST_JOINT_MISS  = 2'd2;

    localparam logic [1:0] REG_FRAME_COUNT = 2'd0;
    localparam logic [1:0] REG_DURATION    = 2'd1;
    localparam logic [1:0] REG_SMOOTH      = 2'd2;
    localparam logic [1:0] REG_ACTIVE_MASK = 2'd3;

    // Smoothstep weight 3 * 2^16.
    localparam logic [17:0] SMOOTH_K = 18'd196608;

    typedef struct packed {
        logic [1:0]         kind;
        logic [4:0]         key_slot;
        logic [3:0]         joint_sel;
        logic [31:0]        time_ms;
        logic signed [15:0] angle_in;
        logic               angle_present;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         out_joint;
        logic               joint_valid;
        logic signed [15:0] joint_degrees;
        logic [31:0]        clamped_ms;
        logic               finished;
        logic               last;
    } t_out_beat;

endpackage

// ===== sv/keyframe_joint_interpolator_top.sv =====
// Keyframe joint interpolator top level: keyframe memories, sequencer, shared multiplier.
// Depends on kji_pkg, kji_div and keyframe_joint_interpolator_top_assert.svh.
//
// Usage: input beats arrive on i_valid/o_ready with a kji_pkg::t_in_beat payload.
// Kind 0 writes a frame time, kind 1 a joint angle or its removal, kind 2 samples.
// Result beats leave on o_valid/i_ready as kji_pkg::t_out_beat; a sample gives
// one beat per active joint in ascending order, or a single status beat.
// The APB port sets frame count, duration, smooth mode and the active joint mask.
// Angle writes pass one more state than frame time writes. A sample searches the
// frame times through the single frame time memory port, runs the 16-step divider,
// adds a smoothing pass in smooth mode and reads the present rows, then works the
// active joints one after another and skips the inactive ones, since both keyframe
// angles come through one angle memory read port and one shared multiplier.
// Only one beat is worked on at a time; o_ready is high only between beats.
// A result beat waits in an output register while the receiver stalls; the
// sequencer holds until that register frees up.
// Reset clears the control registers and marks the joint present rows empty;
// frame times and angles are undefined until written.
`include "keyframe_joint_interpolator_top_assert.svh"
module keyframe_joint_interpolator_top #(
    parameter int MAX_FRAMES = 32,
    parameter int NUM_JOINTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  kji_pkg::t_in_beat i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output kji_pkg::t_out_beat o_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int FI_W = $clog2(MAX_FRAMES);
    localparam int NW   = $clog2(MAX_FRAMES + 1);
    localparam int AW   = FI_W + kji_pkg::JOINT_W;
    localparam int AD   = MAX_FRAMES * kji_pkg::JOINTS;

    typedef enum logic [4:0] {
        S_IDLE, S_DEC, S_WP1, S_SAMP, S_T0, S_RD, S_CMP, S_MIX, S_DIV,
        S_SQ, S_SM2, S_SM3, S_P0, S_P1, S_P2, S_JA, S_JB, S_JM, S_JR, S_ONE
    } t_state;

    t_state r_state;

    logic [5:0]  r_frame_count;
    logic [31:0] r_duration;
    logic        r_smooth;
    logic [15:0] r_active;

    kji_pkg::t_in_beat  r_in;
    kji_pkg::t_out_beat r_one;
    kji_pkg::t_out_beat r_odata;
    logic               r_ovalid;

    logic [31:0] r_cl;
    logic        r_fin;
    logic [31:0] r_tb;
    logic [31:0] r_ta;
    logic [FI_W-1:0] r_bi;
    logic [FI_W-1:0] r_ai;
    logic [FI_W-1:0] r_i;
    logic [16:0] r_mix;
    logic signed [51:0] r_prod;
    logic [15:0] r_pb;
    logic [3:0]  r_j;
    logic signed [15:0] r_a;
    logic [MAX_FRAMES-1:0] r_row_vld;

    logic [31:0] r_ft_mem [MAX_FRAMES];
    logic signed [15:0] r_ang_mem [AD];
    logic [15:0] r_pres_mem [MAX_FRAMES];
    logic [31:0] r_ft_rd;
    logic signed [15:0] r_ang_rd;
    logic [15:0] r_pres_rd;
    logic        r_pres_vld;

    logic [NW-1:0]   w_nframes;
    logic [15:0]     w_jmask;
    logic [15:0]     w_both;
    logic [15:0]     w_miss;
    logic [3:0]      w_first_miss;
    logic [15:0]     w_rest;
    logic            w_fi_ok;
    logic            w_ji_ok;
    logic [FI_W-1:0] w_fi;
    logic [15:0]     w_jbit;
    logic            w_out_free;
    logic            w_load;
    kji_pkg::t_out_beat w_load_data;
    logic [FI_W-1:0] w_ft_raddr;
    logic [FI_W-1:0] w_pres_raddr;
    logic [AW-1:0]   w_ang_raddr;
    logic            w_pres_we;
    logic [15:0]     w_pres_wdata;
    logic [15:0]     w_pres_row;
    logic            w_div_start;
    logic            w_div_done;
    logic [15:0]     w_div_q;
    logic [31:0]     w_div_num;
    logic [31:0]     w_div_den;
    logic signed [16:0] w_diff;
    logic signed [32:0] w_ma;
    logic signed [18:0] w_mb;
    logic signed [51:0] w_mp;
    logic [50:0]        w_sround;
    logic signed [35:0] w_v;
    logic [35:0]        w_abs;
    logic [35:0]        w_rq;
    logic signed [15:0] w_deg;
    logic               w_cfg_wr;

    // Configuration port.
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_duration    <= '0;
            r_smooth      <= 1'b0;
            r_active      <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                kji_pkg::REG_FRAME_COUNT: r_frame_count <= pwdata[5:0];
                kji_pkg::REG_DURATION:    r_duration    <= pwdata;
                kji_pkg::REG_SMOOTH:      r_smooth      <= pwdata[0];
                kji_pkg::REG_ACTIVE_MASK: r_active      <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            kji_pkg::REG_FRAME_COUNT: prdata = {26'd0, r_frame_count};
            kji_pkg::REG_DURATION:    prdata = r_duration;
            kji_pkg::REG_SMOOTH:      prdata = {31'd0, r_smooth};
            kji_pkg::REG_ACTIVE_MASK: prdata = {16'd0, r_active};
        endcase
    end

    // Derived values.
    assign w_nframes = (32'(r_frame_count) > 32'(MAX_FRAMES)) ? NW'(MAX_FRAMES)
                                                              : NW'(r_frame_count);

    always_comb begin
        for (int j = 0; j < kji_pkg::JOINTS; j++) begin
            w_jmask[j] = r_active[j] && (j < NUM_JOINTS);
        end
    end

    assign w_fi_ok  = 32'(r_in.key_slot) < 32'(MAX_FRAMES);
    assign w_ji_ok  = 32'(r_in.joint_sel) < 32'(NUM_JOINTS);
    assign w_fi     = FI_W'(r_in.key_slot);
    assign w_jbit   = 16'(1) << r_in.joint_sel;
    assign w_pres_row = r_pres_vld ? r_pres_rd : 16'd0;
    assign w_both   = r_pb & w_pres_row;
    assign w_miss   = w_jmask & ~w_both;
    assign w_rest   = w_jmask & ~((16'(2) << r_j) - 16'(1));

    always_comb begin
        w_first_miss = '0;
        for (int j = kji_pkg::JOINTS - 1; j >= 0; j--) begin
            if (w_miss[j]) begin
                w_first_miss = 4'(j);
            end
        end
    end

    // Memory addressing.
    always_comb begin
        w_ft_raddr   = (r_state == S_RD) ? r_i : '0;
        w_pres_raddr = w_fi;
        if (r_state == S_P0) begin
            w_pres_raddr = r_bi;
        end else if (r_state == S_P1) begin
            w_pres_raddr = r_ai;
        end
        w_ang_raddr = (r_state == S_JB) ? {r_ai, r_j} : {r_bi, r_j};
        w_pres_we    = (r_state == S_WP1);
        w_pres_wdata = r_in.angle_present ? (w_pres_row | w_jbit) : (w_pres_row & ~w_jbit);
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DEC) && (r_in.kind == kji_pkg::KIND_FRAME_TIME) && w_fi_ok) begin
            r_ft_mem[w_fi] <= r_in.time_ms;
        end
        r_ft_rd <= r_ft_mem[w_ft_raddr];
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DEC) && (r_in.kind == kji_pkg::KIND_ANGLE) && w_fi_ok && w_ji_ok
            && r_in.angle_present) begin
            r_ang_mem[{w_fi, r_in.joint_sel}] <= r_in.angle_in;
        end
        r_ang_rd <= r_ang_mem[w_ang_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_pres_we) begin
            r_pres_mem[w_fi] <= w_pres_wdata;
        end
        r_pres_rd  <= r_pres_mem[w_pres_raddr];
        r_pres_vld <= r_row_vld[w_pres_raddr];
    end

    // Shared multiplier.
    assign w_diff = {r_ang_rd[15], r_ang_rd} - {r_a[15], r_a};

    always_comb begin
        unique case (r_state)
            S_SQ: begin
                w_ma = {16'd0, r_mix};
                w_mb = {2'd0, r_mix};
            end
            S_SM2: begin
                w_ma = {1'b0, r_prod[31:0]};
                w_mb = {1'b0, kji_pkg::SMOOTH_K - {r_mix, 1'b0}};
            end
            S_JM: begin
                w_ma = {{16{w_diff[16]}}, w_diff};
                w_mb = {2'd0, r_mix};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_mp     = w_ma * w_mb;
    assign w_sround = 51'(r_prod) + (51'(1) << 31);

    // Rounding of the blended angle, halves away from zero.
    assign w_v   = ({{20{r_a[15]}}, r_a} <<< 16) + 36'(r_prod);
    assign w_abs = w_v[35] ? 36'(-w_v) : 36'(w_v);
    assign w_rq  = (w_abs + 36'd32768) >> 16;
    assign w_deg = w_v[35] ? -16'(w_rq) : 16'(w_rq);

    // Divider.
    assign w_div_num   = r_cl - r_tb;
    assign w_div_den   = r_ta - r_tb;
    assign w_div_start = (r_state == S_MIX) && (r_ai != r_bi) && (r_ta > r_tb)
                         && (r_cl >= r_tb);

    kji_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    // Output register loading.
    assign w_out_free = !r_ovalid || i_ready;

    always_comb begin
        w_load      = 1'b0;
        w_load_data = r_one;
        if (r_state == S_ONE) begin
            w_load = w_out_free;
        end else if (r_state == S_JR) begin
            w_load = w_out_free;
            w_load_data.status        = kji_pkg::ST_OK;
            w_load_data.out_joint     = r_j;
            w_load_data.joint_valid   = 1'b1;
            w_load_data.joint_degrees = w_deg;
            w_load_data.clamped_ms    = r_cl;
            w_load_data.finished      = r_fin;
            w_load_data.last          = (w_rest == 16'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
        if (w_load) begin
            r_odata <= w_load_data;
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;
    assign o_ready = (r_state == S_IDLE);

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_mix     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_in    <= i_data;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_in.kind == kji_pkg::KIND_ANGLE && w_fi_ok && w_ji_ok) begin
                        r_state <= S_WP1;
                    end else if (r_in.kind == kji_pkg::KIND_SAMPLE) begin
                        r_state <= S_SAMP;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_WP1: begin
                    r_row_vld[w_fi] <= 1'b1;
                    r_state         <= S_IDLE;
                end
                S_SAMP: begin
                    r_cl  <= (r_in.time_ms < r_duration) ? r_in.time_ms : r_duration;
                    r_fin <= (r_in.time_ms >= r_duration);
                    if (w_nframes == '0) begin
                        r_one   <= '{status: kji_pkg::ST_NOT_LOADED, last: 1'b1, default: '0};
                        r_state <= S_ONE;
                    end else begin
                        r_state <= S_T0;
                    end
                end
                S_T0: begin
                    r_tb <= r_ft_rd;
                    r_ta <= r_ft_rd;
                    r_bi <= '0;
                    r_ai <= '0;
                    r_i  <= FI_W'(1);
                    r_state <= (w_nframes == NW'(1)) ? S_MIX : S_RD;
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_ai <= r_i;
                    if (r_ft_rd <= r_cl) begin
                        r_bi <= r_i;
                        r_tb <= r_ft_rd;
                        if (NW'(r_i) == w_nframes - NW'(1)) begin
                            r_state <= S_MIX;
                        end else begin
                            r_i     <= r_i + FI_W'(1);
                            r_state <= S_RD;
                        end
                    end else begin
                        r_ta    <= r_ft_rd;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_mix   <= '0;
                    r_state <= w_div_start ? S_DIV : S_P0;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_mix   <= {1'b0, w_div_q};
                        r_state <= r_smooth ? S_SQ : S_P0;
                    end
                end
                S_SQ: begin
                    r_prod  <= w_mp;
                    r_state <= S_SM2;
                end
                S_SM2: begin
                    r_prod  <= w_mp;
                    r_state <= S_SM3;
                end
                S_SM3: begin
                    r_mix   <= w_sround[48:32];
                    r_state <= S_P0;
                end
                S_P0: begin
                    r_state <= S_P1;
                end
                S_P1: begin
                    r_pb    <= w_pres_row;
                    r_state <= S_P2;
                end
                S_P2: begin
                    if (w_miss != 16'd0) begin
                        r_one   <= '{status: kji_pkg::ST_JOINT_MISS, out_joint: w_first_miss,
                                     last: 1'b1, default: '0};
                        r_state <= S_ONE;
                    end else if (w_jmask == 16'd0) begin
                        r_one   <= '{status: kji_pkg::ST_OK, clamped_ms: r_cl,
                                     finished: r_fin, last: 1'b1, default: '0};
                        r_state <= S_ONE;
                    end else begin
                        r_j     <= '0;
                        r_state <= S_JA;
                    end
                end
                S_JA: begin
                    if (w_jmask[r_j]) begin
                        r_state <= S_JB;
                    end else begin
                        r_j <= r_j + 4'd1;
                    end
                end
                S_JB: begin
                    r_a     <= r_ang_rd;
                    r_state <= S_JM;
                end
                S_JM: begin
                    r_prod  <= w_mp;
                    r_state <= S_JR;
                end
                S_JR: begin
                    if (w_out_free) begin
                        if (w_rest == 16'd0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 4'd1;
                            r_state <= S_JA;
                        end
                    end
                end
                S_ONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `KJI_ASSERT(a_err_is_last, o_valid && (o_data.status != kji_pkg::ST_OK) |-> o_data.last,
                "error result without last")
    `KJI_ASSERT(a_joint_active, o_valid && o_data.joint_valid |-> w_jmask[o_data.out_joint],
                "angle for an inactive joint")
    `KJI_ASSERT(a_div_owner, w_div_done |-> (r_state == S_DIV), "divider finished unexpectedly")
    `KJI_NEVER(a_mix_range, r_mix[16] && (r_mix[15:0] != 16'd0), "mix fraction above one")

endmodule

// ===== sv/kji_div.sv =====
// Restoring divider producing a 16-bit fraction quotient, one bit per cycle.
// Depends on nothing; used by keyframe_joint_interpolator_top.
module kji_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);

    logic [31:0] r_rem;
    logic [31:0] r_den;
    logic [15:0] r_quot;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_rem2;
    logic        w_ge;

    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = w_rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_den  <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? 32'(w_rem2 - {1'b0, r_den}) : w_rem2[31:0];
                r_quot <= {r_quot[14:0], w_ge};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
